/* rtl/sentence_window_poly_hash_macros.svh */
// assertion macros used by swph_back in the sentence window hash rtl
// needs clk and arst_n in the scope where a macro is used
`ifndef SENTENCE_WINDOW_POLY_HASH_MACROS_SVH
`define SENTENCE_WINDOW_POLY_HASH_MACROS_SVH

// same-cycle implication, disabled during reset
`define SWPH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SWPH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/swph_pkg.sv */
// shared types and constants for the sentence window hash block
// no dependencies
package swph_pkg;

	localparam logic [31:0] HASH_BASE       = 32'd101;
	localparam logic [15:0] LEN_MAX         = 16'hFFFF;
	localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
	localparam int          MAX_WINDOW_DEF  = 16;
	localparam int          QUEUE_DEPTH     = 4;
	localparam logic [7:0]  DELIMITER_RESET = 8'd46;
	localparam logic [3:0]  WWIDTH_RESET    = 4'd0;

	// configuration register indexes
	localparam logic [0:0] REG_DELIMITER    = 1'b0;
	localparam logic [0:0] REG_WINDOW_WIDTH = 1'b1;

	// one closed sentence handed from front to back
	typedef struct packed {
		logic [31:0] hash;
		logic [31:0] power;
		logic [15:0] length;
		logic [31:0] index;
		logic        eot;
	} swph_rec_t;

endpackage

/* rtl/swph_front.sv */
// front part: takes text bytes, keeps the running sentence hash and closes sentences
// depends on swph_pkg
module swph_front
	import swph_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] delimiter,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // text_byte
	input  logic       s_tlast,   // end_of_text
	output logic       q_push,
	input  logic       q_ready,
	output swph_rec_t  q_data
);

	logic [31:0] cur_hash_q;
	logic [31:0] cur_pow_q;
	logic [15:0] cur_len_q;
	logic [31:0] count_q;

	logic        accept;
	logic        is_delim;
	logic [31:0] nxt_hash;
	logic [31:0] nxt_pow;
	logic [15:0] nxt_len;

	assign s_tready = q_ready;
	assign accept   = s_tvalid && s_tready;
	assign is_delim = (s_tdata == delimiter);

	assign nxt_hash = cur_hash_q * HASH_BASE + {24'd0, s_tdata};
	assign nxt_pow  = cur_pow_q * HASH_BASE;
	assign nxt_len  = (cur_len_q == LEN_MAX) ? cur_len_q : cur_len_q + 16'd1;

	assign q_push = accept && (is_delim || s_tlast);

	always_comb begin
		q_data.index = count_q;
		q_data.eot   = s_tlast;
		if (is_delim) begin
			q_data.hash   = cur_hash_q;
			q_data.power  = cur_pow_q;
			q_data.length = cur_len_q;
		end else begin
			// last byte of the text joins the sentence it closes
			q_data.hash   = nxt_hash;
			q_data.power  = nxt_pow;
			q_data.length = nxt_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_hash_q <= '0;
			cur_pow_q  <= 32'd1;
			cur_len_q  <= '0;
			count_q    <= '0;
		end else if (accept) begin
			if (is_delim || s_tlast) begin
				cur_hash_q <= '0;
				cur_pow_q  <= 32'd1;
				cur_len_q  <= '0;
				if (s_tlast) begin
					count_q <= '0;
				end else if (count_q != COUNT_MAX) begin
					count_q <= count_q + 32'd1;
				end
			end else begin
				cur_hash_q <= nxt_hash;
				cur_pow_q  <= nxt_pow;
				cur_len_q  <= nxt_len;
			end
		end
	end

endmodule

/* rtl/swph_fifo.sv */
// short queue of closed sentences between front and back
// depends on swph_pkg
module swph_fifo
	import swph_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      push_ready,
	input  swph_rec_t push_data,
	output logic      pop_valid,
	input  logic      pop,
	output swph_rec_t pop_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	swph_rec_t     slots_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != (AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

endmodule

/* rtl/swph_back.sv */
// back part: stores each sentence in the ring and folds the window hash
// depends on swph_pkg and sentence_window_poly_hash_macros.svh
`include "sentence_window_poly_hash_macros.svh"

module swph_back
	import swph_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  win_span,
	input  logic        q_valid,
	output logic        q_ready,
	input  swph_rec_t   q_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // sentence_index, sentence_length, window_hash
	output logic        m_tuser    // window_full
);

	localparam int KW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WMAX = MAX_WINDOW - 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FOLD = 3'b010,
		ST_LAST = 3'b100
	} state_t;

	state_t        state_q;
	swph_rec_t     rec_q;
	logic          full_q;
	logic [KW-1:0] ptr_q;
	logic [KW-1:0] k_q;
	logic [31:0]   acc_q;
	logic [31:0]   accpow_q;

	logic [31:0]   ring_hash_q  [MAX_WINDOW];
	logic [31:0]   ring_power_q [MAX_WINDOW];
	logic [31:0]   rd_hash_q;
	logic [31:0]   rd_power_q;

	logic          out_vld_q;
	logic [31:0]   out_idx_q;
	logic [15:0]   out_len_q;
	logic [31:0]   out_hash_q;
	logic          out_full_q;

	logic [KW-1:0] w_eff;
	logic          pop;
	logic          rec_full;
	logic          rd_en;
	logic [KW-1:0] rd_k;
	logic [KW:0]   slot_sum;
	logic [KW-1:0] rd_addr;
	logic [31:0]   result;
	logic          load_out;
	logic [KW-1:0] ptr_next;

	assign w_eff    = (int'(win_span) > WMAX) ? KW'(WMAX) : KW'(win_span);
	assign q_ready  = (state_q == ST_IDLE);
	assign pop      = q_valid && q_ready;
	assign rec_full = (q_data.index >= 32'(w_eff));

	// read the oldest window member first, then step towards the newest
	assign rd_k  = (state_q == ST_IDLE) ? w_eff : k_q;
	assign rd_en = (pop && rec_full && (w_eff != '0)) || ((state_q == ST_FOLD) && (k_q != '0));

	// slot = ptr - k modulo the ring depth
	assign slot_sum = {1'b0, ptr_q} + (KW+1)'(MAX_WINDOW) - {1'b0, rd_k};
	assign rd_addr  = (slot_sum >= (KW+1)'(MAX_WINDOW)) ?
	                  KW'(slot_sum - (KW+1)'(MAX_WINDOW)) : KW'(slot_sum);

	assign result   = rec_q.hash * accpow_q + acc_q;
	assign load_out = (state_q == ST_LAST) && (!out_vld_q || m_tready);
	assign ptr_next = (ptr_q == KW'(WMAX)) ? '0 : ptr_q + KW'(1);

	always_ff @(posedge clk) begin
		if (pop) begin
			ring_hash_q[ptr_q]  <= q_data.hash;
			ring_power_q[ptr_q] <= q_data.power;
		end
		if (rd_en) begin
			rd_hash_q  <= ring_hash_q[rd_addr];
			rd_power_q <= ring_power_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= q_data;
		end
		if (load_out) begin
			out_idx_q  <= rec_q.index;
			out_len_q  <= rec_q.length;
			out_hash_q <= full_q ? result : '0;
			out_full_q <= full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			full_q    <= 1'b0;
			ptr_q     <= '0;
			k_q       <= '0;
			acc_q     <= '0;
			accpow_q  <= 32'd1;
			out_vld_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						full_q   <= rec_full;
						acc_q    <= '0;
						accpow_q <= 32'd1;
						if (rec_full && (w_eff != '0)) begin
							k_q     <= w_eff - KW'(1);
							state_q <= ST_FOLD;
						end else begin
							state_q <= ST_LAST;
						end
					end
				end
				ST_FOLD: begin
					// one ring entry folded per cycle
					acc_q    <= rd_hash_q * accpow_q + acc_q;
					accpow_q <= accpow_q * rd_power_q;
					if (k_q != '0) begin
						k_q <= k_q - KW'(1);
					end else begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					if (load_out) begin
						ptr_q   <= rec_q.eot ? '0 : ptr_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_hash_q, out_len_q, out_idx_q};
	assign m_tuser  = out_full_q;

	`SWPH_ASSERT_SAME(a_fold_needs_window, state_q == ST_FOLD, full_q && (w_eff != '0), "fold without a full window")
	`SWPH_ASSERT_SAME(a_short_window_plain, (state_q == ST_LAST) && !full_q, (acc_q == '0) && (accpow_q == 32'd1), "accumulator moved for a short window")
	`SWPH_ASSERT_NEXT(a_ptr_rewinds, load_out && rec_q.eot, ptr_q == '0, "ring pointer kept after end of text")
	`SWPH_ASSERT_SAME(a_out_from_last, $rose(out_vld_q), $past(state_q == ST_LAST), "result shown without a finished fold")

endmodule

/* rtl/sentence_window_poly_hash.sv */
// sentence window hash, top level
// Input stream: one text byte per transfer in s_tdata, s_tlast marks the last byte of a text.
// Output stream: one result per sentence; m_tdata holds index, length and window hash,
// m_tuser says whether the window was full (hash is zero otherwise).
// Config port: cfg_we with cfg_addr 0 writes the delimiter, cfg_addr 1 the window width;
// write only while the block is idle.
// The front takes a byte every cycle while its queue has room. Once its window is full a
// sentence goes through the back as a pop in IDLE, one fold step per earlier sentence in FOLD
// through the single ring read port and 32x32 multiplier pair, and a finishing step in LAST that
// loads the output register behind m_tvalid; otherwise it goes from IDLE straight to LAST.
// The back takes a new sentence from the queue only once the last one has left LAST.
// Reset clears the sentence state, count, ring pointer, queue and output valid flag and sets
// the delimiter to '.' and the window width to 0; ring contents are not cleared.
// When the receiver stalls, the result holds in the output register, the back waits, the
// queue fills, and then s_tready drops.
module sentence_window_poly_hash
	import swph_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // sentence_index [31:0], sentence_length [47:32], window_hash [79:48]
	output logic        m_tuser    // window_full
);

	logic [7:0] delimiter_q;
	logic [3:0] wwidth_q;

	logic       q_push;
	logic       q_push_ready;
	swph_rec_t  q_push_data;
	logic       q_pop_valid;
	logic       q_pop;
	swph_rec_t  q_pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIMITER_RESET;
			wwidth_q    <= WWIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DELIMITER:    delimiter_q <= cfg_wdata;
				REG_WINDOW_WIDTH: wwidth_q    <= cfg_wdata[3:0];
				default:          delimiter_q <= delimiter_q;
			endcase
		end
	end

	swph_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.delimiter (delimiter_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_push    (q_push),
		.q_ready   (q_push_ready),
		.q_data    (q_push_data)
	);

	swph_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop        (q_pop),
		.pop_data   (q_pop_data)
	);

	swph_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.win_span     (wwidth_q),
		.q_valid      (q_pop_valid),
		.q_ready      (q_pop),
		.q_data       (q_pop_data),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule

/* sim/tb.sv */
// testbench for sentence_window_poly_hash: streams text bytes, predicts each sentence result
// and compares it with the block output under random idling and stalls
// depends on swph_pkg and the sentence_window_poly_hash rtl
`timescale 1ns / 1ps

module tb;
	import swph_pkg::*;

	typedef struct packed {
		logic [31:0] index;
		logic [15:0] length;
		logic [31:0] hash;
		logic        full;
	} sentence_result_t;

	// predicts the result of every closed sentence and checks what comes out
	class sentence_hash_scoreboard;
		logic [31:0] ring_hash [16];
		logic [31:0] ring_power [16];
		logic [3:0]  ring_wr;
		logic [31:0] cur_hash;
		logic [31:0] cur_power;
		logic [15:0] cur_len;
		logic [31:0] sentence_cnt;
		logic [7:0]  delimiter;
		logic [3:0]  win_span;
		sentence_result_t expected_q[$];
		int errors;

		function new();
			errors = 0;
			foreach (ring_hash[i]) begin
				ring_hash[i] = '0;
				ring_power[i] = '0;
			end
			clear_text();
			delimiter = DELIMITER_RESET;
			win_span = WWIDTH_RESET;
		endfunction

		function void clear_text();
			cur_hash = '0;
			cur_power = 32'd1;
			cur_len = '0;
			sentence_cnt = '0;
			ring_wr = '0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [7:0] value);
			if (idx == REG_DELIMITER) begin
				delimiter = value;
			end else begin
				win_span = value[3:0];
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// fold oldest-first, each newer one in front: H(A||B) = H(A) * 101^|B| + H(B)
		function void close_sentence();
			sentence_result_t r;
			logic [31:0] acc;
			logic [31:0] acc_pow;
			logic [3:0]  slot;
			ring_hash[ring_wr] = cur_hash;
			ring_power[ring_wr] = cur_power;
			r.index = sentence_cnt;
			r.length = cur_len;
			r.full = (sentence_cnt >= {28'd0, win_span});
			acc = '0;
			acc_pow = 32'd1;
			if (r.full) begin
				for (int k = win_span; k >= 0; k--) begin
					slot = ring_wr - 4'(k);
					acc = ring_hash[slot] * acc_pow + acc;
					acc_pow = acc_pow * ring_power[slot];
				end
			end
			r.hash = r.full ? acc : '0;
			expected_q.insert(expected_q.size(), r);
			ring_wr = ring_wr + 4'd1;
			if (sentence_cnt != COUNT_MAX)
				sentence_cnt = sentence_cnt + 32'd1;
			cur_hash = '0;
			cur_power = 32'd1;
			cur_len = '0;
		endfunction

		function void note_byte(logic [7:0] b, logic eot);
			if (b == delimiter) begin
				close_sentence();
			end else begin
				cur_hash = cur_hash * HASH_BASE + {24'd0, b};
				cur_power = cur_power * HASH_BASE;
				if (cur_len != LEN_MAX)
					cur_len = cur_len + 16'd1;
				if (eot)
					close_sentence();
			end
			if (eot)
				clear_text();
		endfunction

		task report(string msg);
			$display("%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [79:0] data, logic full);
			sentence_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result index %0d", data[31:0]));
				return;
			end
			want = expected_q.pop_front();
			if (data[31:0] !== want.index)
				report($sformatf("index %0d, want %0d", data[31:0], want.index));
			if (data[47:32] !== want.length)
				report($sformatf("index %0d: length %0d, want %0d",
					want.index, data[47:32], want.length));
			if (data[79:48] !== want.hash)
				report($sformatf("index %0d: hash %08h, want %08h",
					want.index, data[79:48], want.hash));
			if (full !== want.full)
				report($sformatf("index %0d: window_full %0b, want %0b",
					want.index, full, want.full));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_addr = '0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // text_byte
	logic        s_tlast = 1'b0; // end_of_text
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;        // sentence_index, sentence_length, window_hash
	logic        m_tuser;        // window_full

	sentence_hash_scoreboard sb = new();

	int tx_idle = 0;
	int rx_idle = 0;
	int phase_bytes = 0;
	int stall_reqs = 0;
	int stall_seen = 0;
	int stall_left = 0;

	sentence_window_poly_hash dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// receiver: checks each transfer, random back-pressure, long hold-off on request
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if (stall_reqs != stall_seen) begin
			stall_seen = stall_reqs;
			stall_left = 300;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	initial begin
		#200_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic set_idling(int mode);
		case (mode)
			0: begin
				tx_idle = 17;
				rx_idle = 65;
			end
			1: begin
				tx_idle = 65;
				rx_idle = 17;
			end
			default: begin
				tx_idle = 0;
				rx_idle = 0;
			end
		endcase
	endtask

	task automatic write_reg(logic [0:0] idx, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic send_byte(logic [7:0] b, logic eot);
		if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eot;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(b, eot);
		phase_bytes++;
	endtask

	// stop sending and wait for every outstanding result, then, if settle is set, let the back settle
	task automatic drain(bit settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		if (settle)
			repeat (64) @(posedge clk);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == sb.delimiter);
		return b;
	endfunction

	function automatic int sentence_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(0, 4);
		else if (r < 95)
			return $urandom_range(5, 12);
		return $urandom_range(13, 40);
	endfunction

	// well-formed text: delimited sentences, the last may lack one; the last byte carries tlast
	task automatic send_text();
		int n_sent;
		int len;
		if ($urandom_range(99) < 70)
			n_sent = $urandom_range(sb.win_span + 1, sb.win_span + 6);
		else
			n_sent = $urandom_range(1, sb.win_span + 6);
		for (int s = 0; s < n_sent; s++) begin
			len = sentence_len();
			for (int i = 0; i < len; i++)
				send_byte(plain_byte(), (s == n_sent - 1) && (i == len - 1) &&
					($urandom_range(1) == 1));
			// the text may already have ended on its last plain byte
			if (s_tlast && s == n_sent - 1 && len > 0)
				return;
			send_byte(sb.delimiter, s == n_sent - 1);
		end
	endtask

	// loose bytes: delimiters and text ends at random spots
	task automatic send_noise();
		int n;
		logic [7:0] b;
		n = $urandom_range(5, 30);
		for (int i = 0; i < n; i++) begin
			b = ($urandom_range(99) < 20) ? sb.delimiter : 8'($urandom_range(1, 255));
			send_byte(b, $urandom_range(99) < 6);
		end
	endtask

	task automatic random_phase(logic [7:0] delim, logic [3:0] width, int mode,
		bit long_stall, bit mid_pause);
		drain(1'b1);
		write_reg(REG_DELIMITER, delim);
		write_reg(REG_WINDOW_WIDTH, {4'd0, width});
		set_idling(mode);
		phase_bytes = 0;
		if (long_stall)
			stall_reqs++;
		while (phase_bytes < 40) begin
			if ($urandom_range(99) < 85)
				send_text();
			else
				send_noise();
			if (mid_pause && phase_bytes >= 20) begin
				mid_pause = 1'b0;
				drain(1'b0);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: '.' ends a sentence, no earlier sentences joined
		set_idling(0);
		send_byte("H", 1'b0);
		send_byte("i", 1'b0);
		send_byte(".", 1'b0);
		send_byte(".", 1'b0);        // empty sentence between two delimiters
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);      // zero byte as ordinary data
		send_byte(".", 1'b1);        // text ends on a delimiter, no trailing piece
		send_byte("z", 1'b1);        // text ends on a plain byte
		send_byte(".", 1'b1);

		// zero as delimiter, window of two
		drain(1'b1);
		write_reg(REG_DELIMITER, 8'h00);
		write_reg(REG_WINDOW_WIDTH, 8'd2);
		send_byte("a", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte("b", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte("c", 1'b1);

		// widest window, top delimiter value
		drain(1'b1);
		write_reg(REG_DELIMITER, 8'hFF);
		write_reg(REG_WINDOW_WIDTH, 8'd15);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFF, 1'b1);

		random_phase(".", 4'd3, 0, 1'b0, 1'b0);
		random_phase(8'hFF, 4'd15, 0, 1'b1, 1'b0);
		random_phase(8'h01, 4'd0, 1, 1'b0, 1'b0);
		random_phase(8'($urandom_range(1, 255)), 4'($urandom_range(0, 15)), 1, 1'b0, 1'b1);
		random_phase(" ", 4'd15, 2, 1'b0, 1'b0);
		random_phase(8'($urandom_range(1, 255)), 4'd8, 2, 1'b1, 1'b0);

		drain(1'b1);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
